FILE: rtl/tmwf_pkg.sv
`default_nettype none

package tmwf_pkg;

	localparam int WINDOW = 5;
	localparam int VAL_W = 24;
	localparam int AGE_W = 3;
	localparam int CNT_W = 3;

	// age codes: empty, freshly inserted, due for replacement
	localparam logic [AGE_W-1:0] AGE_EMPTY = AGE_W'(0);
	localparam logic [AGE_W-1:0] AGE_NEW = AGE_W'(1);
	localparam logic [AGE_W-1:0] AGE_OLD = AGE_W'(WINDOW + 1);

	// sum of three middle entries and its magnitude
	localparam int SUM_W = VAL_W + 2;
	localparam int MAG_W = VAL_W + 1;

	// divide by three: floor(m / 3) == (m * ceil(2^26 / 3)) >> 26 for m < 2^25
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W = 25;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
	localparam int PROD_W = MAG_W + RECIP_W;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [AGE_W-1:0]        age;
	} entry_t;

	// what a cell shows its neighbors: aged entry and whether it stays ahead of the sample
	typedef struct packed {
		entry_t ent;
		logic   keep;
	} link_t;

	localparam link_t LINK_HEAD = '{ent: '0, keep: 1'b1};
	localparam link_t LINK_TAIL = '{ent: '0, keep: 1'b0};

endpackage

`default_nettype wire

FILE: rtl/tmwf_cell.sv
`default_nettype none

module tmwf_cell
	import tmwf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    load,
	input  wire logic signed [VAL_W-1:0] sample,
	input  wire link_t                   prev_lnk,
	input  wire link_t                   next_lnk,
	input  wire logic                    rm_in,
	output link_t                        lnk,
	output logic                         rm_out,
	output entry_t                       ent
);

	entry_t entry_q;
	entry_t aged;
	entry_t entry_nxt;
	link_t  lo_lnk;
	link_t  hi_lnk;
	logic   my_rm;

	always_comb begin
		aged.value = entry_q.value;
		aged.age   = (entry_q.age == AGE_EMPTY) ? AGE_EMPTY : entry_q.age + AGE_W'(1);
		lnk.ent    = aged;
		// equal entries above the dropped slot stay ahead of the sample, below it fall behind
		lnk.keep   = rm_in ? ($signed(entry_q.value) > $signed(sample))
		                   : ($signed(entry_q.value) >= $signed(sample));

		// first empty or oldest entry along the row drops out
		my_rm  = !rm_in && (aged.age == AGE_EMPTY || aged.age == AGE_OLD);
		rm_out = rm_in || my_rm;
	end

	always_comb begin
		// list with the dropped entry squeezed out: own place and the one above
		lo_lnk = rm_out ? next_lnk : lnk;
		hi_lnk = rm_in ? lnk : prev_lnk;

		if (lo_lnk.keep) begin
			entry_nxt = lo_lnk.ent;
		end else if (!hi_lnk.keep) begin
			entry_nxt = hi_lnk.ent;
		end else begin
			entry_nxt = '{value: sample, age: AGE_NEW};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q <= entry_nxt;
		end
	end

	assign ent = entry_q;

endmodule

`default_nettype wire

FILE: rtl/trimmed_mean_window_filter.sv
`default_nettype none

// trimmed mean filter over a sorted window of five samples
//
// input channel: sample with in_valid / in_ready; output channel: filtered and
// filled_count with out_valid / out_ready. each input transaction yields exactly
// one output transaction, in order.
// a row of five cells holds the window sorted largest first; on an accepted
// transaction every cell ages its entry, the oldest (or an empty) entry drops
// out and the new sample lands in sorted place, all in the same clock.
// the mean of the three middle entries then goes through a sum stage, a
// multiply-by-reciprocal stage (divide by three, truncated toward zero) and the
// output register, which drives out_valid.
// throughput is one transaction per cycle while the receiver keeps up; a
// stalled receiver holds the output register and the stall backs up stage by
// stage to in_ready, without losing a result.
// reset clears the window to empty entries of value zero and drops any
// transaction in flight; empty entries count as zeros in the mean.

module trimmed_mean_window_filter
	import tmwf_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [VAL_W-1:0] sample,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [VAL_W-1:0]      filtered,
	output logic [CNT_W-1:0]             filled_count
);

	link_t                   lnk [WINDOW];
	logic [WINDOW:0]         rm;
	entry_t [WINDOW-1:0]     win;
	logic                    load;
	logic [CNT_W-1:0]        filled_now;

	// stage valids: window holds an unread result, sum, product, output
	logic                    v0_q;
	logic                    v1_s1;
	logic                    v2_s2;
	logic                    out_valid_q;
	logic                    ready1;
	logic                    ready2;
	logic                    ready3;

	logic signed [SUM_W-1:0] sum_s1;
	logic [CNT_W-1:0]        cnt_s1;
	logic [PROD_W-1:0]       prod_s2;
	logic                    neg_s2;
	logic [CNT_W-1:0]        cnt_s2;
	logic signed [VAL_W-1:0] filtered_q;
	logic [CNT_W-1:0]        filled_count_q;
	logic [MAG_W-1:0]        mag;
	logic [VAL_W-1:0]        quot;

	assign ready3   = !out_valid_q || out_ready;
	assign ready2   = !v2_s2 || ready3;
	assign ready1   = !v1_s1 || ready2;
	assign in_ready = !v0_q || ready1;
	assign load     = in_valid && in_ready;

	// row of cells, removal search ripples from the front
	assign rm[0] = 1'b0;

	for (genvar j = 0; j < WINDOW; j++) begin : g_cell
		link_t prev_lnk;
		link_t next_lnk;

		if (j == 0) begin : g_head
			assign prev_lnk = LINK_HEAD;
		end else begin : g_mid_prev
			assign prev_lnk = lnk[j-1];
		end

		if (j == WINDOW - 1) begin : g_tail
			assign next_lnk = LINK_TAIL;
		end else begin : g_mid_next
			assign next_lnk = lnk[j+1];
		end

		tmwf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (load),
			.sample   (sample),
			.prev_lnk (prev_lnk),
			.next_lnk (next_lnk),
			.rm_in    (rm[j]),
			.lnk      (lnk[j]),
			.rm_out   (rm[j+1]),
			.ent      (win[j])
		);
	end

	// entries holding real samples
	always_comb begin
		filled_now = '0;
		for (int j = 0; j < WINDOW; j++) begin
			filled_now = filled_now + CNT_W'(win[j].age != AGE_EMPTY);
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q        <= 1'b0;
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v0_q <= in_valid;
			end
			if (ready1) begin
				v1_s1 <= v0_q;
			end
			if (ready2) begin
				v2_s2 <= v1_s1;
			end
			if (ready3) begin
				out_valid_q <= v2_s2;
			end
		end
	end

	// magnitude of the sum, fits since |sum| <= 3 * 2^23
	always_comb begin
		if (sum_s1[SUM_W-1]) begin
			mag = MAG_W'(-sum_s1);
		end else begin
			mag = MAG_W'(sum_s1);
		end
		quot = prod_s2[RECIP_SHIFT +: VAL_W];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ready1) begin
			sum_s1 <= SUM_W'(win[1].value) + SUM_W'(win[2].value) + SUM_W'(win[3].value);
			cnt_s1 <= filled_now;
		end
		if (ready2) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP);
			neg_s2  <= sum_s1[SUM_W-1];
			cnt_s2  <= cnt_s1;
		end
		if (ready3) begin
			filtered_q     <= neg_s2 ? -$signed(quot) : $signed(quot);
			filled_count_q <= cnt_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered     = filtered_q;
	assign filled_count = filled_count_q;

`ifndef ASSERT_OFF
	// window stays sorted, largest first
	for (genvar j = 0; j < WINDOW - 1; j++) begin : g_sorted_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			$signed(win[j].value) >= $signed(win[j+1].value))
			else $error("window out of order");
	end

	// window changes only on an accepted transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(win))
		else $error("window changed without a transaction");

	// each transaction fills one more entry until the window is full
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (filled_now == (($past(filled_now) == CNT_W'(WINDOW)) ?
			CNT_W'(WINDOW) : $past(filled_now) + CNT_W'(1))))
		else $error("fill count stepped wrong");

	// an accepted transaction always finds an entry to replace
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> rm[WINDOW])
		else $error("no entry to replace");

	// a result never reports an empty window
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (filled_count != CNT_W'(0)))
		else $error("result with empty window");
`endif

endmodule

`default_nettype wire
